[rtl/ccfd_pkg.sv]
`timescale 1ns / 1ps

package ccfd_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int EVENT_W = 4;
  localparam int COUNT_W = 17;
  localparam int DLEN_W  = 16;
  localparam int HDR_LEN = 5;
  localparam int HIDX_W  = $clog2(HDR_LEN);

  // Protocol constants
  localparam logic [BYTE_W-1:0]  SYNC_BYTE           = 8'h55;
  localparam logic [BYTE_W-1:0]  CRC_POLY            = 8'h07;
  localparam logic [COUNT_W-1:0] DEFAULT_MAX_PAYLOAD = 17'd300;

  // Default depth of the queue between front and engine
  localparam int QUEUE_DEPTH_DEF = 4;

  // Event codes reported with each byte
  typedef enum logic [EVENT_W-1:0] {
    EV_DISCARD     = 4'd0,
    EV_SYNC        = 4'd1,
    EV_HDR_BYTE    = 4'd2,
    EV_HDR_OK      = 4'd3,
    EV_HDR_CRC_ERR = 4'd4,
    EV_OVERSIZE    = 4'd5,
    EV_PAY_BYTE    = 4'd6,
    EV_PKT_OK      = 4'd7,
    EV_PAY_CRC_ERR = 4'd8
  } event_t;

  // Queue entry: received byte plus its sync classification
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_sync;
  } q_entry_t;

  // CRC-8, MSB first, one byte
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/ccfd_if.sv]
`timescale 1ns / 1ps

// Received byte channel
interface ccfd_byte_if;
  import ccfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

// Event channel, one word per received byte
interface ccfd_event_if;
  import ccfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [BYTE_W-1:0]  echo_byte;
  logic [COUNT_W-1:0] payload_index;
  logic [BYTE_W-1:0]  packet_kind;
  logic [DLEN_W-1:0]  data_len;
  logic [BYTE_W-1:0]  option_len;

  modport source(output valid, output event_res, output echo_byte, output payload_index,
                 output packet_kind, output data_len, output option_len, input ready);
  modport sink(input valid, input event_res, input echo_byte, input payload_index,
               input packet_kind, input data_len, input option_len, output ready);
endinterface

[rtl/crc8_checked_frame_deframer_top.sv]
`timescale 1ns / 1ps

// Serial frame receiver with CRC-8 header and payload checks.
// rx: one received byte per word (valid/ready). ev: one event word per byte,
// carrying the event code, the byte, its payload index and the header fields.
// cfg_we/cfg_wdata: writes the largest accepted data+option+CRC byte count;
// write it only while the block is idle.
// A byte accepted on rx enters a small queue; the parser engine takes one byte
// per cycle from it while the event slot is free and no replay runs. Each byte
// passes through the queue and then the event output register. A header CRC
// error makes the engine re-scan the five stored header bytes before it takes
// the next byte; the queue keeps accepting meanwhile until it fills.
// Reset (rst, synchronous) empties the queue, drops any pending event, puts
// the parser back to hunting for sync and loads the size limit with 300.
// If the receiver holds ev.ready low, the event stays in the output register,
// the engine stops, and rx.ready drops once the queue is full.

module crc8_checked_frame_deframer_top #(
  parameter int QUEUE_DEPTH = ccfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ccfd_pkg::COUNT_W-1:0] cfg_wdata,
  ccfd_byte_if.sink                    rx,
  ccfd_event_if.source                 ev
);
  import ccfd_pkg::*;

  logic [COUNT_W-1:0] max_payload;
  logic               q_valid;
  q_entry_t           q_entry;
  logic               q_pop;

  // Size limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= DEFAULT_MAX_PAYLOAD;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  ccfd_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  ccfd_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .max_payload (max_payload),
    .ev          (ev)
  );

endmodule

[rtl/ccfd_front.sv]
`timescale 1ns / 1ps

module ccfd_front #(
  parameter int DEPTH = ccfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ccfd_byte_if.sink          rx,
  output logic               q_valid,
  output ccfd_pkg::q_entry_t q_entry,
  input  logic               q_pop
);
  import ccfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          queue [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign rx.ready = (count != CNT_W'(DEPTH));
  assign push     = rx.valid && rx.ready;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_entry  = queue[rd_ptr];

  // Classify and store each accepted word
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].data    <= rx.rx_byte;
      queue[wr_ptr].is_sync <= (rx.rx_byte == SYNC_BYTE);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/ccfd_engine.sv]
`timescale 1ns / 1ps

module ccfd_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  ccfd_pkg::q_entry_t           q_entry,
  output logic                         q_pop,
  input  logic [ccfd_pkg::COUNT_W-1:0] max_payload,
  ccfd_event_if.source                 ev
);
  import ccfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ENG_RUN    = 2'b01,
    ENG_REPLAY = 2'b10
  } eng_state_t;

  eng_state_t         state;
  logic [HIDX_W-1:0]  rep_idx;

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  header_store [HDR_LEN];
  logic [COUNT_W-1:0] byte_position, byte_position_next;
  logic [COUNT_W-1:0] payload_total, payload_total_next;
  logic [BYTE_W-1:0]  running_crc, running_crc_next;

  logic               fire;
  logic               replaying;
  logic               step_en;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_sync;
  logic [HIDX_W-1:0]  hdr_pos;
  logic [COUNT_W-1:0] hdr_total;
  logic [COUNT_W-1:0] pos_inc;
  logic               store_we;
  event_t             ev_code;
  logic [COUNT_W-1:0] ev_idx;
  logic               hdr_valid;

  // Engine takes a queued word only when the event slot is free
  assign replaying = (state == ENG_REPLAY);
  assign fire      = (state == ENG_RUN) && q_valid && (!ev.valid || ev.ready);
  assign q_pop     = fire;
  assign step_en   = fire || replaying;

  // Byte source: queue, or stored header bytes during replay
  always_comb begin
    if (replaying) begin
      cur_byte = header_store[rep_idx];
      cur_sync = (header_store[rep_idx] == SYNC_BYTE);
    end else begin
      cur_byte = q_entry.data;
      cur_sync = q_entry.is_sync;
    end
  end

  assign hdr_pos   = (byte_position > COUNT_W'(HDR_LEN - 1)) ? HIDX_W'(HDR_LEN - 1)
                                                             : byte_position[HIDX_W-1:0];
  assign hdr_total = COUNT_W'({header_store[0], header_store[1]})
                   + COUNT_W'(header_store[2]) + COUNT_W'(1);
  assign pos_inc   = byte_position + COUNT_W'(1);

  // Frame parser step
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    payload_total_next = payload_total;
    running_crc_next   = running_crc;
    store_we           = 1'b0;
    ev_code            = EV_DISCARD;
    ev_idx             = '0;
    hdr_valid          = 1'b0;
    case (phase)
      PH_HEADER: begin
        store_we = 1'b1;
        if (hdr_pos < HIDX_W'(HDR_LEN - 1)) begin
          running_crc_next   = crc8_update(running_crc, cur_byte);
          byte_position_next = COUNT_W'(hdr_pos) + COUNT_W'(1);
          ev_code            = EV_HDR_BYTE;
        end else if (running_crc != cur_byte) begin
          phase_next = PH_HUNT;
          ev_code    = EV_HDR_CRC_ERR;
        end else begin
          payload_total_next = hdr_total;
          byte_position_next = '0;
          running_crc_next   = '0;
          hdr_valid          = 1'b1;
          if (hdr_total > max_payload) begin
            phase_next = PH_HUNT;
            ev_code    = EV_OVERSIZE;
          end else begin
            phase_next = PH_PAYLOAD;
            ev_code    = EV_HDR_OK;
          end
        end
      end
      PH_PAYLOAD: begin
        ev_idx    = byte_position;
        hdr_valid = 1'b1;
        if (pos_inc < payload_total) begin
          running_crc_next   = crc8_update(running_crc, cur_byte);
          byte_position_next = pos_inc;
          ev_code            = EV_PAY_BYTE;
        end else begin
          phase_next = PH_HUNT;
          ev_code    = (running_crc == cur_byte) ? EV_PKT_OK : EV_PAY_CRC_ERR;
        end
      end
      default: begin
        // hunting, also any stray phase code
        phase_next = PH_HUNT;
        if (cur_sync) begin
          phase_next         = PH_HEADER;
          byte_position_next = '0;
          running_crc_next   = '0;
          ev_code            = EV_SYNC;
        end
      end
    endcase
  end

  // Header bytes; replay only writes below the entry it reads
  always_ff @(posedge clk) begin
    if (step_en && store_we) begin
      header_store[hdr_pos] <= cur_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
      payload_total <= '0;
      running_crc   <= '0;
    end else if (step_en) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      payload_total <= payload_total_next;
      running_crc   <= running_crc_next;
    end
  end

  // Replay sequencer: five header bytes after a header CRC error
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ENG_RUN;
      rep_idx <= '0;
    end else begin
      case (state)
        ENG_RUN: begin
          if (fire && ev_code == EV_HDR_CRC_ERR) begin
            state   <= ENG_REPLAY;
            rep_idx <= '0;
          end
        end
        ENG_REPLAY: begin
          if (rep_idx == HIDX_W'(HDR_LEN - 1)) begin
            state <= ENG_RUN;
          end else begin
            rep_idx <= rep_idx + HIDX_W'(1);
          end
        end
        default: begin
          state <= ENG_RUN;
        end
      endcase
    end
  end

  // Event output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else if (fire) begin
      ev.valid <= 1'b1;
    end else if (ev.ready) begin
      ev.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ev.event_res     <= ev_code;
      ev.echo_byte     <= cur_byte;
      ev.payload_index <= ev_idx;
      ev.packet_kind   <= hdr_valid ? header_store[3] : '0;
      ev.data_len      <= hdr_valid ? {header_store[0], header_store[1]} : '0;
      ev.option_len    <= hdr_valid ? header_store[2] : '0;
    end
  end

endmodule
